### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the scan unit checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, muted during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared widths, types and tables of the seven-segment scan unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ssd_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGITS   = 4;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CELLS    = VALUE_W;
    localparam int SEL_W    = 8;
    localparam int SEG_W    = 8;
    localparam int TDATA_W  = SEL_W + SEG_W;

    localparam logic [SEG_W-1:0] DOT_MASK = 8'h7F;
    localparam logic [SEG_W-1:0] NO_MASK  = 8'hFF;
    localparam logic [SEG_W-1:0] SEG_DARK = 8'hFF;

    localparam logic [SEL_W-1:0] SEL_THOUSANDS = 8'hF7;
    localparam logic [SEL_W-1:0] SEL_HUNDREDS  = 8'hFB;
    localparam logic [SEL_W-1:0] SEL_TENS      = 8'hFD;
    localparam logic [SEL_W-1:0] SEL_UNITS     = 8'hFE;

    typedef enum logic [1:0] {
        POS_THOUSANDS = 2'd0,
        POS_HUNDREDS  = 2'd1,
        POS_TENS      = 2'd2,
        POS_UNITS     = 2'd3
    } pos_t;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] bits;
        logic [BCD_W-1:0]   bcd;
        logic               ovf;
    } ssd_word_t;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] dig);
        logic [SEG_W-1:0] pat;
        begin
            case (dig)
                4'd0:    pat = 8'hC0;
                4'd1:    pat = 8'hF9;
                4'd2:    pat = 8'hA4;
                4'd3:    pat = 8'hB0;
                4'd4:    pat = 8'h99;
                4'd5:    pat = 8'h92;
                4'd6:    pat = 8'h82;
                4'd7:    pat = 8'hF8;
                4'd8:    pat = 8'h80;
                4'd9:    pat = 8'h90;
                default: pat = SEG_DARK;
            endcase
            return pat;
        end
    endfunction

    function automatic logic [SEL_W-1:0] pos_select(input pos_t pos);
        logic [SEL_W-1:0] sel;
        begin
            unique case (pos)
                POS_THOUSANDS: sel = SEL_THOUSANDS;
                POS_HUNDREDS:  sel = SEL_HUNDREDS;
                POS_TENS:      sel = SEL_TENS;
                POS_UNITS:     sel = SEL_UNITS;
                default:       sel = SEL_UNITS;
            endcase
            return sel;
        end
    endfunction

endpackage

### sv/four_digit_seven_segment_scan_unit.sv
// Takes one 32-bit value per word and returns four scan words, thousands first
// and units last (tlast), showing the value modulo 10000 with the thousands
// decimal point lit when the value is 10000 or more. A value runs through a
// chain of 32 conversion cells, one binary bit per cell; the chain advances
// only while its last cell is empty or the output stage can take a value. The
// output stage sends one scan word per cycle while m_tready is high, and it
// takes the next value as its units word is accepted, while the chain holds the values that follow.
// ----------------------------------------------------------------------------
// four_digit_seven_segment_scan_unit
// Binary to four-digit seven-segment scan words, streaming in and out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_digit_seven_segment_scan_unit
    import ssd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [VALUE_W-1:0] s_tdata,   // [31:0] value
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [7:0] digit_select, [15:8] segments
    output logic               m_tlast
);

    ssd_word_t        chain [0:CELLS];
    logic             adv;
    logic             ser_ready;
    logic [SEL_W-1:0] digit_select;
    logic [SEG_W-1:0] segments;

    assign chain[0].valid = s_tvalid;
    assign chain[0].bits  = s_tdata;
    assign chain[0].bcd   = '0;
    assign chain[0].ovf   = 1'b0;

    assign adv      = ~chain[CELLS].valid | ser_ready;
    assign s_tready = adv;

    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        ssd_dd_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .in_word  (chain[i]),
            .out_word (chain[i+1])
        );
    end

    ssd_serializer u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_word      (chain[CELLS]),
        .in_ready     (ser_ready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .digit_select (digit_select),
        .segments     (segments),
        .last_digit   (m_tlast)
    );

    assign m_tdata = {segments, digit_select};

endmodule

### sv/ssd_dd_cell.sv
// ----------------------------------------------------------------------------
// ssd_dd_cell
// One shift-and-add-3 step on four BCD digits, registered toward the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_dd_cell
    import ssd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      adv,
    input  ssd_word_t in_word,
    output ssd_word_t out_word
);

    logic               valid_reg;
    logic [VALUE_W-1:0] bits_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic               ovf_reg;

    logic [BCD_W-1:0]   adj;
    logic [VALUE_W-1:0] bits_next;
    logic [BCD_W-1:0]   bcd_next;
    logic               ovf_next;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (in_word.bcd[i*4 +: 4] >= 4'd5)
            begin
                adj[i*4 +: 4] = in_word.bcd[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adj[i*4 +: 4] = in_word.bcd[i*4 +: 4];
            end
        end
        bcd_next  = {adj[BCD_W-2:0], in_word.bits[VALUE_W-1]};
        ovf_next  = in_word.ovf | adj[BCD_W-1];
        bits_next = {in_word.bits[VALUE_W-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_word.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bits_reg <= bits_next;
            bcd_reg  <= bcd_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign out_word.valid = valid_reg;
    assign out_word.bits  = bits_reg;
    assign out_word.bcd   = bcd_reg;
    assign out_word.ovf   = ovf_reg;

endmodule

### sv/ssd_serializer.sv
// ----------------------------------------------------------------------------
// ssd_serializer
// Holds one converted value and emits its four digit words in scan order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ssd_serializer
    import ssd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ssd_word_t        in_word,
    output logic             in_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [SEL_W-1:0] digit_select,
    output logic [SEG_W-1:0] segments,
    output logic             last_digit
);

    logic             busy_reg;
    pos_t             pos_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic             ovf_reg;

    logic             take;
    logic             load;
    logic [3:0]       dig;
    logic [SEG_W-1:0] mask;

    assign take     = busy_reg & m_tready;
    assign last_digit = (pos_reg == POS_UNITS);
    assign in_ready = ~busy_reg | (take & last_digit);
    assign load     = in_ready & in_word.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_THOUSANDS;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= POS_THOUSANDS;
        end
        else if (take)
        begin
            if (last_digit)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_t'(pos_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bcd_reg <= in_word.bcd;
            ovf_reg <= in_word.ovf;
        end
    end

    always_comb
    begin
        unique case (pos_reg)
            POS_THOUSANDS: dig = bcd_reg[15:12];
            POS_HUNDREDS:  dig = bcd_reg[11:8];
            POS_TENS:      dig = bcd_reg[7:4];
            POS_UNITS:     dig = bcd_reg[3:0];
            default:       dig = bcd_reg[3:0];
        endcase
        mask = (pos_reg == POS_THOUSANDS && ovf_reg) ? DOT_MASK : NO_MASK;
    end

    assign m_tvalid     = busy_reg;
    assign digit_select = pos_select(pos_reg);
    assign segments     = seg_pattern(dig) & mask;

endmodule

### sv/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the scan word stream of the scan unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ssd_checker
    import ssd_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata,
    input logic               m_tlast
);

    logic stalled;
    logic sent_first;
    logic is_units;
    logic not_first;

    assign stalled    = m_tvalid & ~m_tready;
    assign sent_first = m_tvalid & m_tready & (m_tdata[7:0] == SEL_THOUSANDS);
    assign is_units   = m_tdata[7:0] == SEL_UNITS;
    assign not_first  = m_tvalid & (m_tdata[7:0] != SEL_THOUSANDS);

    `ASSERT_NEXT(a_hold, clk, rst_n, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `ASSERT_SAME(a_last_units, clk, rst_n, m_tvalid, m_tlast == is_units)
    `ASSERT_SAME(a_dot_first, clk, rst_n, not_first, m_tdata[15] == 1'b1)
    `ASSERT_NEXT(a_run_order, clk, rst_n, sent_first, m_tvalid && m_tdata[7:0] == SEL_HUNDREDS)

endmodule

bind four_digit_seven_segment_scan_unit ssd_checker u_ssd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
